FILE: src/bandpass_jump_peak_detector_assert.svh
// assertion macros used by the detector rtl
`ifndef BANDPASS_JUMP_PEAK_DETECTOR_ASSERT_SVH
`define BANDPASS_JUMP_PEAK_DETECTOR_ASSERT_SVH

// same-cycle implication
`define BJPD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define BJPD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: src/bjpd_pkg.sv
package bjpd_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int FILT_W    = 40;
    localparam int ORDER_W   = 7;
    localparam int GAP_W     = 16;
    localparam int FACTOR_W  = 8;
    localparam int FLOOR_W   = 31;
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 2;
    localparam int POS_W     = 19;
    localparam int REQ_W     = 2;
    localparam int CIDX_W    = 7;

    localparam int MUL_AW    = 128;
    localparam int MUL_BW    = 64;
    localparam int MUL_PW    = MUL_AW + MUL_BW;
    localparam int MUL_CNT_W = $clog2(MUL_BW + 1);

    localparam logic [ORDER_W-1:0]  ORDER_RST  = 7'd100;
    localparam logic [GAP_W-1:0]    GAP_RST    = 16'd600;
    localparam logic [FACTOR_W-1:0] FACTOR_RST = 8'd10;
    localparam logic [FLOOR_W-1:0]  FLOOR_RST  = 31'd5368709;

    typedef enum logic [REQ_W-1:0] {
        REQ_COEF   = 2'd0,
        REQ_SAMPLE = 2'd1,
        REQ_FETCH  = 2'd2
    } req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORDER  = 2'd0,
        CFG_GAP    = 2'd1,
        CFG_FACTOR = 2'd2,
        CFG_FLOOR  = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic              start;
        logic [MUL_AW-1:0] a;
        logic [MUL_BW-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

endpackage

FILE: src/bjpd_mul.sv
module bjpd_mul
    import bjpd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  mul_req_t          req,
    output mul_stat_t         stat,
    output logic [MUL_PW-1:0] prod
);

    logic [MUL_AW-1:0]    a_reg;
    logic [MUL_AW-1:0]    hi_reg;
    logic [MUL_BW-1:0]    lo_reg;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [MUL_AW:0]      add_sum;

    // shift-add, one multiplier bit per cycle
    assign add_sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : '0);

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + MUL_CNT_W'(1);
            if (cnt_reg == MUL_CNT_W'(MUL_BW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg  <= req.a;
            hi_reg <= '0;
            lo_reg <= req.b;
        end
        else if (busy_reg)
        begin
            hi_reg <= add_sum[MUL_AW:1];
            lo_reg <= {add_sum[0], lo_reg[MUL_BW-1:1]};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign prod      = {hi_reg, lo_reg};

endmodule

FILE: src/bandpass_jump_peak_detector.sv
// coefficient and sample loads are taken back to back while idle; a fetch reads the list in S_F_RD,
// answers from S_F_OUT, and the next request is taken back in idle, later while an earlier answer waits
// record compute after the final sample is set by the fir mac loop and the shared
// 64-step shift-add multiplier
// reset clears control and restores register defaults; sample, tap and result memories
// are not cleared, and results are unavailable until the first record is computed
module bandpass_jump_peak_detector
    import bjpd_pkg::*;
#(
    parameter int MAX_SAMPLES = 524288,
    parameter int MAX_TAPS    = 128
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [23:0]          s_tdata,   // coef_index, data_value, zero pad
    input  logic [REQ_W-1:0]     s_tuser,   // req_type
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,   // peak_position, zero pad
    output logic [0:0]           m_tuser,   // peak_valid
    output logic                 m_tlast,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    `include "bandpass_jump_peak_detector_assert.svh"

    localparam int AW  = $clog2(MAX_SAMPLES);
    localparam int CW  = $clog2(MAX_SAMPLES + 1);
    localparam int TW  = $clog2(MAX_TAPS);
    localparam int TIW = CW + 2;
    localparam int DW  = CW + GAP_W;

    typedef enum logic [22:0] {
        S_IDLE    = 23'h000001,
        S_TAP_RD  = 23'h000002,
        S_TAP_MAC = 23'h000004,
        S_SQ_GO   = 23'h000008,
        S_SQ_WAIT = 23'h000010,
        S_V1_GO   = 23'h000020,
        S_V1_WAIT = 23'h000040,
        S_V2_GO   = 23'h000080,
        S_V2_WAIT = 23'h000100,
        S_TH_GO   = 23'h000200,
        S_TH_WAIT = 23'h000400,
        S_FL_GO   = 23'h000800,
        S_FL_WAIT = 23'h001000,
        S_P2_RD   = 23'h002000,
        S_P2_LD   = 23'h004000,
        S_NY_WAIT = 23'h008000,
        S_P2_CHK  = 23'h010000,
        S_DD_GO   = 23'h020000,
        S_DD_WAIT = 23'h040000,
        S_P2_NEXT = 23'h080000,
        S_P2_FIN  = 23'h100000,
        S_F_RD    = 23'h200000,
        S_F_OUT   = 23'h400000
    } state_t;

    state_t state_reg, state_next;

    logic [ORDER_W-1:0]  order_reg;
    logic [GAP_W-1:0]    gap_reg;
    logic [FACTOR_W-1:0] factor_reg;
    logic [FLOOR_W-1:0]  floor_reg;

    logic [CW-1:0] cnt_reg, cnt_next, cnt_eff;
    logic          ready_reg, ready_next;
    logic          have_reg, have_next;
    logic [CW-1:0] pcnt_reg, pcnt_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic          mvalid_reg, mvalid_next;
    logic          hit_reg, hit_next;

    logic [CW-1:0]              i_reg;
    logic [TW-1:0]              m_reg;
    logic signed [FILT_W-1:0]   acc_reg;
    logic signed [63:0]         sum_reg;
    logic [127:0]               sq_reg, v1_reg, var_reg, thr_reg;
    logic signed [63:0]         nfloor_reg, d_reg;
    logic signed [FILT_W-1:0]   y_reg, run_val_reg;
    logic [AW-1:0]              run_idx_reg;
    logic                       tap_ok_reg;
    logic [POS_W-1:0]           m_pos_reg;
    logic                       m_last_reg, m_user_reg;

    logic signed [SAMPLE_W-1:0] samp_mem [MAX_SAMPLES];
    logic signed [SAMPLE_W-1:0] coef_mem [MAX_TAPS];
    logic signed [FILT_W-1:0]   filt_mem [MAX_SAMPLES];
    logic [AW-1:0]              list_mem [MAX_SAMPLES];
    logic signed [SAMPLE_W-1:0] samp_rdata, coef_rdata;
    logic signed [FILT_W-1:0]   filt_rdata;
    logic [AW-1:0]              list_rdata;

    logic                        s_acc, is_sample, is_coef;
    logic [CIDX_W-1:0]           coef_index;
    logic signed [SAMPLE_W-1:0]  data_value;
    logic [TW-1:0]               taps_m1;
    logic [ORDER_W-2:0]          centre;
    logic signed [TIW-1:0]       tap_t;
    logic                        tap_ok;
    logic signed [31:0]          tap_prod;
    logic                        last_i, far, cand, push;
    logic [FILT_W-1:0]           acc_mag, y_mag;
    logic [63:0]                 sum_mag;
    logic signed [63:0]          ny_mag;
    logic [2*FACTOR_W-1:0]       fact_sq;
    logic [AW-1:0]               gap_diff;
    mul_req_t                    mul_rq;
    mul_stat_t                   mul_st;
    logic [MUL_PW-1:0]           mul_prod;

    assign coef_index = s_tdata[CIDX_W-1:0];
    assign data_value = s_tdata[CIDX_W+SAMPLE_W-1:CIDX_W];
    assign s_tready   = (state_reg == S_IDLE);
    assign s_acc      = s_tvalid && s_tready;
    assign is_sample  = s_acc && (req_t'(s_tuser) == REQ_SAMPLE);
    assign is_coef    = s_acc && (req_t'(s_tuser) == REQ_COEF);
    assign cnt_eff    = ready_reg ? '0 : cnt_reg;

    assign taps_m1 = (int'(order_reg) > MAX_TAPS - 1) ? TW'(MAX_TAPS - 1) : TW'(order_reg);
    assign centre  = order_reg[ORDER_W-1:1];
    assign tap_t   = $signed(TIW'(i_reg)) + $signed(TIW'(centre)) - $signed(TIW'(m_reg));
    assign tap_ok  = !tap_t[TIW-1] && (tap_t[TIW-2:0] < (CW+1)'(cnt_reg));
    assign tap_prod = samp_rdata * coef_rdata;
    assign last_i  = ((i_reg + CW'(1)) == cnt_reg);

    assign acc_mag = acc_reg[FILT_W-1] ? (~acc_reg + FILT_W'(1)) : acc_reg;
    assign y_mag   = filt_rdata[FILT_W-1] ? (~filt_rdata + FILT_W'(1)) : filt_rdata;
    assign sum_mag = sum_reg[63] ? (~sum_reg + 64'd1) : sum_reg;
    assign ny_mag  = $signed(mul_prod[63:0]);
    assign fact_sq = (2*FACTOR_W)'(factor_reg) * (2*FACTOR_W)'(factor_reg);

    assign gap_diff = i_reg[AW-1:0] - run_idx_reg;
    assign far      = DW'(gap_diff) > DW'(gap_reg);
    assign cand     = mul_prod[127:0] > thr_reg;
    assign push     = ((state_reg == S_DD_WAIT) && mul_st.done && cand && have_reg && far)
                   || ((state_reg == S_P2_FIN) && have_reg);

    // shared multiplier operand select
    always_comb
    begin
        mul_rq = '0;
        case (state_reg)
            S_SQ_GO:
            begin
                mul_rq.start = 1'b1;
                mul_rq.a     = MUL_AW'(acc_mag);
                mul_rq.b     = MUL_BW'(acc_mag);
            end
            S_V1_GO:
            begin
                mul_rq.start = 1'b1;
                mul_rq.a     = sq_reg;
                mul_rq.b     = MUL_BW'(cnt_reg);
            end
            S_V2_GO:
            begin
                mul_rq.start = 1'b1;
                mul_rq.a     = MUL_AW'(sum_mag);
                mul_rq.b     = sum_mag;
            end
            S_TH_GO:
            begin
                mul_rq.start = 1'b1;
                mul_rq.a     = var_reg;
                mul_rq.b     = MUL_BW'(fact_sq);
            end
            S_FL_GO:
            begin
                mul_rq.start = 1'b1;
                mul_rq.a     = MUL_AW'(floor_reg);
                mul_rq.b     = MUL_BW'(cnt_reg);
            end
            S_P2_LD:
            begin
                mul_rq.start = 1'b1;
                mul_rq.a     = MUL_AW'(y_mag);
                mul_rq.b     = MUL_BW'(cnt_reg);
            end
            S_DD_GO:
            begin
                mul_rq.start = 1'b1;
                mul_rq.a     = MUL_AW'($unsigned(d_reg));
                mul_rq.b     = $unsigned(d_reg);
            end
            default:
            begin
                mul_rq = '0;
            end
        endcase
    end

    bjpd_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_rq),
        .stat  (mul_st),
        .prod  (mul_prod)
    );

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        ready_next  = ready_reg;
        have_next   = have_reg;
        pcnt_next   = pcnt_reg;
        ptr_next    = ptr_reg;
        mvalid_next = mvalid_reg && !m_tready;
        hit_next    = hit_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_acc)
                begin
                    case (req_t'(s_tuser))
                        REQ_SAMPLE:
                        begin
                            ready_next = 1'b0;
                            cnt_next   = (cnt_eff < CW'(MAX_SAMPLES)) ? cnt_eff + CW'(1)
                                                                     : cnt_eff;
                            if (s_tlast)
                            begin
                                state_next = S_TAP_RD;
                            end
                        end
                        REQ_FETCH:
                        begin
                            hit_next   = ready_reg && (ptr_reg < pcnt_reg);
                            state_next = S_F_RD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_TAP_RD:  state_next = S_TAP_MAC;
            S_TAP_MAC: state_next = (m_reg == taps_m1) ? S_SQ_GO : S_TAP_RD;
            S_SQ_GO:   state_next = S_SQ_WAIT;
            S_SQ_WAIT:
            begin
                if (mul_st.done)
                begin
                    state_next = last_i ? S_V1_GO : S_TAP_RD;
                end
            end
            S_V1_GO:   state_next = S_V1_WAIT;
            S_V1_WAIT: if (mul_st.done) state_next = S_V2_GO;
            S_V2_GO:   state_next = S_V2_WAIT;
            S_V2_WAIT: if (mul_st.done) state_next = S_TH_GO;
            S_TH_GO:   state_next = S_TH_WAIT;
            S_TH_WAIT: if (mul_st.done) state_next = S_FL_GO;
            S_FL_GO:   state_next = S_FL_WAIT;
            S_FL_WAIT:
            begin
                if (mul_st.done)
                begin
                    have_next  = 1'b0;
                    pcnt_next  = '0;
                    state_next = S_P2_RD;
                end
            end
            S_P2_RD:   state_next = S_P2_LD;
            S_P2_LD:   state_next = S_NY_WAIT;
            S_NY_WAIT: if (mul_st.done) state_next = S_P2_CHK;
            S_P2_CHK:
            begin
                state_next = ((d_reg > 64'sd0) && (d_reg > nfloor_reg)) ? S_DD_GO : S_P2_NEXT;
            end
            S_DD_GO:   state_next = S_DD_WAIT;
            S_DD_WAIT:
            begin
                if (mul_st.done)
                begin
                    if (cand && (!have_reg || far))
                    begin
                        have_next = 1'b1;
                    end
                    if (push)
                    begin
                        pcnt_next = pcnt_reg + CW'(1);
                    end
                    state_next = S_P2_NEXT;
                end
            end
            S_P2_NEXT: state_next = last_i ? S_P2_FIN : S_P2_RD;
            S_P2_FIN:
            begin
                if (push)
                begin
                    pcnt_next = pcnt_reg + CW'(1);
                end
                ready_next = 1'b1;
                ptr_next   = '0;
                state_next = S_IDLE;
            end
            S_F_RD:    state_next = S_F_OUT;
            S_F_OUT:
            begin
                if (!mvalid_reg || m_tready)
                begin
                    mvalid_next = 1'b1;
                    if (hit_reg)
                    begin
                        ptr_next = ptr_reg + CW'(1);
                    end
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            ready_reg  <= 1'b0;
            have_reg   <= 1'b0;
            pcnt_reg   <= '0;
            ptr_reg    <= '0;
            mvalid_reg <= 1'b0;
            hit_reg    <= 1'b0;
            order_reg  <= ORDER_RST;
            gap_reg    <= GAP_RST;
            factor_reg <= FACTOR_RST;
            floor_reg  <= FLOOR_RST;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            ready_reg  <= ready_next;
            have_reg   <= have_next;
            pcnt_reg   <= pcnt_next;
            ptr_reg    <= ptr_next;
            mvalid_reg <= mvalid_next;
            hit_reg    <= hit_next;
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_ORDER:  order_reg  <= cfg_data[ORDER_W-1:0];
                    CFG_GAP:    gap_reg    <= cfg_data[GAP_W-1:0];
                    CFG_FACTOR: factor_reg <= cfg_data[FACTOR_W-1:0];
                    CFG_FLOOR:  floor_reg  <= cfg_data[FLOOR_W-1:0];
                    default:    order_reg  <= order_reg;
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                i_reg   <= '0;
                m_reg   <= '0;
                acc_reg <= '0;
                sum_reg <= '0;
                sq_reg  <= '0;
            end
            S_TAP_RD:  tap_ok_reg <= tap_ok;
            S_TAP_MAC:
            begin
                acc_reg <= acc_reg + (tap_ok_reg ? FILT_W'(tap_prod) : '0);
                m_reg   <= m_reg + TW'(1);
            end
            S_SQ_GO:   sum_reg <= sum_reg + 64'(acc_reg);
            S_SQ_WAIT:
            begin
                if (mul_st.done)
                begin
                    sq_reg  <= sq_reg + mul_prod[127:0];
                    i_reg   <= i_reg + CW'(1);
                    m_reg   <= '0;
                    acc_reg <= '0;
                end
            end
            S_V1_WAIT: if (mul_st.done) v1_reg <= mul_prod[127:0];
            S_V2_WAIT: if (mul_st.done) var_reg <= v1_reg - mul_prod[127:0];
            S_TH_WAIT:
            begin
                if (mul_st.done)
                begin
                    thr_reg <= (|mul_prod[MUL_PW-1:128]) ? '1 : mul_prod[127:0];
                end
            end
            S_FL_WAIT:
            begin
                if (mul_st.done)
                begin
                    nfloor_reg <= $signed(mul_prod[63:0]);
                    i_reg      <= '0;
                end
            end
            S_P2_LD:   y_reg <= filt_rdata;
            S_NY_WAIT:
            begin
                if (mul_st.done)
                begin
                    d_reg <= (y_reg[FILT_W-1] ? -ny_mag : ny_mag) - sum_reg;
                end
            end
            S_DD_WAIT:
            begin
                if (mul_st.done && cand && (!have_reg || far || (y_reg >= run_val_reg)))
                begin
                    run_val_reg <= y_reg;
                    run_idx_reg <= i_reg[AW-1:0];
                end
            end
            S_P2_NEXT: i_reg <= i_reg + CW'(1);
            S_F_OUT:
            begin
                if (!mvalid_reg || m_tready)
                begin
                    m_user_reg <= hit_reg;
                    m_pos_reg  <= hit_reg ? POS_W'(list_rdata) : '0;
                    m_last_reg <= hit_reg && (ptr_reg == (pcnt_reg - CW'(1)));
                end
            end
            default:
            begin
                tap_ok_reg <= tap_ok_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (is_sample && (cnt_eff < CW'(MAX_SAMPLES)))
        begin
            samp_mem[cnt_eff[AW-1:0]] <= data_value;
        end
        if (state_reg == S_TAP_RD)
        begin
            samp_rdata <= samp_mem[tap_t[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_coef && (int'(coef_index) < MAX_TAPS))
        begin
            coef_mem[TW'(coef_index)] <= data_value;
        end
        if (state_reg == S_TAP_RD)
        begin
            coef_rdata <= coef_mem[m_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_SQ_GO)
        begin
            filt_mem[i_reg[AW-1:0]] <= acc_reg;
        end
        if (state_reg == S_P2_RD)
        begin
            filt_rdata <= filt_mem[i_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            list_mem[pcnt_reg[AW-1:0]] <= run_idx_reg;
        end
        if (state_reg == S_F_RD)
        begin
            list_rdata <= list_mem[ptr_reg[AW-1:0]];
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {(24 - POS_W)'(0), m_pos_reg};
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    `BJPD_ASSERT_IMP(a_mul_start_idle, mul_rq.start, !mul_st.busy)
    `BJPD_ASSERT_IMP(a_ptr_in_list, ready_reg, ptr_reg <= pcnt_reg)
    `BJPD_ASSERT_IMP(a_list_in_record, ready_reg, pcnt_reg <= cnt_reg)
    `BJPD_ASSERT_NXT(a_fetch_answers, (state_reg == S_F_OUT) && (!mvalid_reg || m_tready), m_tvalid)

endmodule

FILE: tb/sv/peak_checker.sv
`timescale 1ns / 1ps

module peak_checker
    import bjpd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [23:0]          s_tdata,
    input  logic [REQ_W-1:0]     s_tuser,
    input  logic                 s_tlast,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [23:0]          m_tdata,
    input  logic [0:0]           m_tuser,
    input  logic                 m_tlast,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   errors,
    output int                   waiting
);

    localparam int REC_DEPTH = 1024;
    localparam int TAP_DEPTH = 128;

    typedef struct {
        logic             found;
        logic [POS_W-1:0] pos;
        logic             last;
    } peak_ans_t;

    peak_ans_t peak_answers[$];

    shortint     samples[REC_DEPTH];
    shortint     taps_h[TAP_DEPTH];
    longint      filt[REC_DEPTH];
    bit          marked[REC_DEPTH];
    int          rec_len;
    int          fetch_ptr;
    int          last_peak;
    bit          have_results;

    logic [ORDER_W-1:0]  order_r;
    logic [GAP_W-1:0]    gap_r;
    logic [FACTOR_W-1:0] factor_r;
    logic [FLOOR_W-1:0]  floor_r;

    function automatic logic [127:0] sat_mul(input logic [127:0] a, input logic [63:0] k);
        logic [191:0] p;
        p = 192'(a) * 192'(k);
        return (p[191:128] != 0) ? {128{1'b1}} : p[127:0];
    endfunction

    function automatic logic [63:0] mag(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // filter the record, then find and merge jump peaks
    task automatic find_peaks();
        int            ntaps, centre, t;
        longint        acc, total, y, d;
        logic [127:0]  sumsq, spread, thr, dsq;
        logic [63:0]   ma;
        bit            have_peak;
        longint        run_val;
        int            run_idx;
        ntaps  = int'(order_r) + 1;
        if (ntaps > TAP_DEPTH)
            ntaps = TAP_DEPTH;
        centre = int'(order_r) / 2;
        total  = 0;
        sumsq  = '0;
        for (int i = 0; i < rec_len; i++)
        begin
            acc = 0;
            for (int m = 0; m < ntaps; m++)
            begin
                t = i + centre - m;
                if (t >= 0 && t < rec_len)
                    acc += longint'(samples[t]) * longint'(taps_h[m]);
            end
            filt[i] = acc;
            total += acc;
            ma = mag(acc);
            sumsq = sumsq + 128'(ma) * 128'(ma);
        end
        ma     = mag(total);
        spread = sat_mul(sumsq, 64'(rec_len)) - 128'(ma) * 128'(ma);
        thr    = sat_mul(spread, 64'(factor_r) * 64'(factor_r));
        have_peak = 0;
        run_val   = 0;
        run_idx   = 0;
        last_peak = 0;
        for (int i = 0; i < rec_len; i++)
        begin
            y = filt[i];
            d = longint'(rec_len) * y - total;
            marked[i] = 0;
            if (d <= 0 || d <= longint'(rec_len) * longint'(floor_r))
                continue;
            dsq = 128'(64'(d)) * 128'(64'(d));
            if (dsq <= thr)
                continue;
            if (!have_peak || (i - run_idx) > int'(gap_r))
                have_peak = 1;
            else if (y < run_val)
                continue;
            else
                marked[run_idx] = 0;
            marked[i] = 1;
            run_val   = y;
            run_idx   = i;
            last_peak = i;
        end
        fetch_ptr    = 0;
        have_results = 1;
    endtask

    task automatic take_request(input req_t rq, input int idx,
                                input shortint val, input bit fin);
        peak_ans_t ans;
        int        p;
        case (rq)
            REQ_COEF:
                taps_h[idx] = val;
            REQ_SAMPLE:
            begin
                if (have_results)
                begin
                    have_results = 0;
                    rec_len      = 0;
                end
                if (rec_len < REC_DEPTH)
                begin
                    samples[rec_len] = val;
                    rec_len++;
                end
                if (fin)
                    find_peaks();
            end
            REQ_FETCH:
            begin
                ans = '{found: 0, pos: '0, last: 0};
                if (have_results)
                begin
                    p = fetch_ptr;
                    while (p < rec_len && !marked[p])
                        p++;
                    if (p < rec_len)
                    begin
                        ans.found = 1;
                        ans.pos   = POS_W'(p);
                        ans.last  = (p == last_peak);
                        fetch_ptr = p + 1;
                    end
                    else
                        fetch_ptr = p;
                end
                peak_answers.push_back(ans);
            end
            default: ;
        endcase
    endtask

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    initial
    begin
        errors       = 0;
        rec_len      = 0;
        fetch_ptr    = 0;
        last_peak    = 0;
        have_results = 0;
        order_r      = ORDER_RST;
        gap_r        = GAP_RST;
        factor_r     = FACTOR_RST;
        floor_r      = FLOOR_RST;
        foreach (taps_h[i])
            taps_h[i] = 0;
    end

    always @(posedge clk)
    begin
        peak_ans_t want;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_ORDER:  order_r  = cfg_data[ORDER_W-1:0];
                    CFG_GAP:    gap_r    = cfg_data[GAP_W-1:0];
                    CFG_FACTOR: factor_r = cfg_data[FACTOR_W-1:0];
                    CFG_FLOOR:  floor_r  = cfg_data[FLOOR_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                take_request(req_t'(s_tuser), int'(s_tdata[6:0]),
                             shortint'(s_tdata[22:7]), s_tlast);
            if (m_tvalid && m_tready)
            begin
                if (peak_answers.size() == 0)
                    report("unexpected response", 1, 0);
                else
                begin
                    want = peak_answers.pop_front();
                    if (m_tuser[0] !== want.found)
                        report("peak_valid", int'(m_tuser[0]), int'(want.found));
                    if (m_tdata[POS_W-1:0] !== want.pos)
                        report("peak_position", int'(m_tdata[POS_W-1:0]), int'(want.pos));
                    if (m_tlast !== want.last)
                        report("peak_last", int'(m_tlast), int'(want.last));
                end
            end
        end
        waiting = peak_answers.size();
    end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench
    import bjpd_pkg::*;
();

    localparam int ITEM_TARGET = 1650;
    localparam int IDLE_LIMIT  = 200000;
    localparam int LONG_HOLD   = 300;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [23:0]          s_tdata;
    logic [REQ_W-1:0]     s_tuser;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [23:0]          m_tdata;
    logic [0:0]           m_tuser;
    logic                 m_tlast;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    int errors;
    int waiting;
    int items;
    int burst_left;
    int idle_cycles;
    bit hold_req;
    int hold_cnt;
    int mode;
    int mode_left;
    int cur_order;

    bandpass_jump_peak_detector dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    peak_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .waiting(waiting)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // receiver stall pattern, with a long hold on demand
    always @(negedge clk)
    begin
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            m_tready <= 1'b0;
        end
        else if (hold_req)
        begin
            hold_req = 0;
            hold_cnt = LONG_HOLD;
            m_tready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(8, 64);
            end
            mode_left--;
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("bandpass_jump_peak_detector verification failed");
            $finish;
        end
    end

    task automatic send(input req_t rq, input int idx, input int val, input bit fin);
        logic [15:0] v;
        logic [6:0]  ix;
        v  = val[15:0];
        ix = idx[6:0];
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            if ($urandom_range(0, 3) != 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= rq;
        s_tdata  <= {1'b0, v, ix};
        s_tlast  <= fin;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        items++;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (waiting != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input int unsigned val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    function automatic int any_value();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    task automatic send_record(input int len);
        int v;
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 5) == 0)
                v = any_value();
            else
                v = int'($urandom_range(0, 16)) - 8;
            send(REQ_SAMPLE, $urandom_range(0, 127), v, i == len - 1);
        end
    endtask

    task automatic load_taps(input bit whole);
        int c;
        c = cur_order / 2;
        for (int i = 0; i < 128; i++)
        begin
            if (whole || i <= cur_order && $urandom_range(0, 1) == 1)
            begin
                if ($urandom_range(0, 1) == 1)
                    send(REQ_COEF, i, any_value(), 1'($urandom_range(0, 1)));
                else
                    send(REQ_COEF, i, (i == c) ? 16384 : int'($urandom_range(0, 64)) - 32, 0);
            end
        end
    endtask

    initial
    begin
        int unsigned gap_v, factor_v, floor_v;
        int          phase, nf;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = REQ_COEF;
        s_tlast    = 1'b0;
        m_tready   = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_ORDER;
        cfg_data   = '0;
        items      = 0;
        burst_left = 0;
        hold_req   = 0;
        hold_cnt   = 0;
        mode       = 0;
        mode_left  = 0;
        idle_cycles = 0;
        cur_order  = 100;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // fetch before any results, unused code, final mark on other requests
        send(REQ_FETCH, 0, 0, 1);
        send(req_t'(2'd3), 127, 32767, 1);
        load_taps(1);
        send(REQ_FETCH, 0, 0, 0);
        settle();

        // extreme samples with order 2, factor 1, floor 0 and gap 0
        write_reg(CFG_ORDER, 2);
        write_reg(CFG_FACTOR, 1);
        write_reg(CFG_FLOOR, 0);
        write_reg(CFG_GAP, 0);
        cur_order = 2;
        send(REQ_SAMPLE, 0, 0, 0);
        send(REQ_SAMPLE, 0, 32767, 0);
        send(REQ_SAMPLE, 0, -32768, 0);
        send(REQ_SAMPLE, 0, 0, 0);
        send(REQ_SAMPLE, 0, 32767, 0);
        send(REQ_SAMPLE, 0, 0, 1);
        repeat (5) send(REQ_FETCH, 0, 0, 0);
        // single sample record has zero spread
        send(REQ_SAMPLE, 0, 1234, 1);
        send(REQ_FETCH, 0, 0, 0);
        send(REQ_FETCH, 0, 0, 0);
        settle();

        phase = 0;
        while (items < ITEM_TARGET)
        begin
            case ($urandom_range(0, 9))
                0: cur_order = 126;
                1: cur_order = 2;
                default: cur_order = $urandom_range(2, 20);
            endcase
            case ($urandom_range(0, 5))
                0: gap_v = 0;
                1: gap_v = 65535;
                default: gap_v = $urandom_range(0, 12);
            endcase
            case ($urandom_range(0, 5))
                0: factor_v = 0;
                1: factor_v = 255;
                default: factor_v = $urandom_range(1, 3);
            endcase
            case ($urandom_range(0, 7))
                0: floor_v = 0;
                1: floor_v = 32'h7fffffff;
                2: floor_v = $urandom;
                default: floor_v = $urandom_range(0, 1 << 20);
            endcase
            write_reg(CFG_ORDER, cur_order);
            if ($urandom_range(0, 2) != 0)
                write_reg(CFG_GAP, gap_v);
            if ($urandom_range(0, 2) != 0)
                write_reg(CFG_FACTOR, factor_v);
            if ($urandom_range(0, 2) != 0)
                write_reg(CFG_FLOOR, floor_v);
            if ($urandom_range(0, 2) == 0)
                load_taps(0);
            if ($urandom_range(0, 9) == 0)
                send(req_t'(2'd3), $urandom_range(0, 127), any_value(),
                     1'($urandom_range(0, 1)));
            send_record($urandom_range(4, 48));
            nf = $urandom_range(1, 8);
            if (phase == 3)
            begin
                hold_req = 1;
                nf = 12;
            end
            repeat (nf) send(REQ_FETCH, $urandom_range(0, 127), any_value(),
                             1'($urandom_range(0, 1)));
            settle();
            phase++;
        end

        settle();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("bandpass_jump_peak_detector verification clean");
        else
            $display("bandpass_jump_peak_detector verification failed");
        $finish;
    end

endmodule
